@@ hw/rtl/sfc_pkg.sv @@
// Shared types and constants for the segmented FIFO cache policy block.
// No dependencies; used by segmented_fifo_cache_policy.
package sfc_pkg;

   localparam int KEY_W   = 64;
   localparam int SIZE_W  = 24;
   localparam int CAP_W   = 40;
   localparam int MD_W    = 4;
   localparam int HITS_W  = 2;
   localparam int SEGS_W  = 3;
   localparam int COUNT_W = 9;
   localparam int CHG_W   = SIZE_W + 1;
   localparam int CSR_W   = 3;

   localparam int NUM_CAP_REGS = 4;

   localparam logic [HITS_W-1:0] HIT_MAX      = 2'd3;
   localparam logic [SEGS_W-1:0] SEGS_RESET   = 3'd3;
   localparam logic [CAP_W-1:0]  CAP_RESET    = 40'd65536;
   localparam logic [MD_W-1:0]   MD_RESET     = 4'd0;

   localparam logic [CSR_W-1:0] CSR_SEGMENTS = 3'd0;
   localparam logic [CSR_W-1:0] CSR_CAP0     = 3'd1;
   localparam logic [CSR_W-1:0] CSR_CAP1     = 3'd2;
   localparam logic [CSR_W-1:0] CSR_CAP2     = 3'd3;
   localparam logic [CSR_W-1:0] CSR_CAP3     = 3'd4;
   localparam logic [CSR_W-1:0] CSR_METADATA = 3'd5;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MISS,
      ST_Q0,
      ST_E0,
      ST_PCHK,
      ST_QT,
      ST_ET
   } state_type;

endpackage

@@ hw/rtl/segmented_fifo_cache_policy.sv @@
// Segmented FIFO cache policy: top level with the control sequencer.
// Depends on sfc_pkg and on sfc_ram for the entry table and segment queues.
//
// Channel  Direction  Ports                                     Transaction
// request  in         start, busy, req_object_key/_size         start & !busy
// response out        rsp_valid, rsp_hit ... rsp_promoted_count rsp_valid, one cycle
// config   in         csr_wr_en, csr_index, csr_wr_data         csr_wr_en
//
// Every access scans the entry table, one entry per cycle. A miss may
// drop entries from segment 0, promote entries out of it and drop entries
// from a promotion segment; all of it is paced by the single read port of
// the entry memory. After reset a clearing pass over every entry runs with
// busy high. The response cannot be stalled; it is shown for one cycle.
module segmented_fifo_cache_policy #(
   parameter int MAX_SEGMENTS = 4,
   parameter int MAX_ENTRIES  = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sfc_pkg::KEY_W-1:0]         req_object_key,
   input  logic [sfc_pkg::SIZE_W-1:0]        req_object_size,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [1:0]                        rsp_hit_segment,
   output logic                              rsp_admitted,
   output logic                              rsp_table_full,
   output logic [sfc_pkg::COUNT_W-1:0]       rsp_evicted_count,
   output logic [sfc_pkg::COUNT_W-1:0]       rsp_promoted_count,
   input  logic                              csr_wr_en,
   input  logic [sfc_pkg::CSR_W-1:0]         csr_index,
   input  logic [sfc_pkg::CAP_W-1:0]         csr_wr_data
);

   localparam int EW    = $clog2(MAX_ENTRIES);
   localparam int SW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int QDEP  = MAX_SEGMENTS * MAX_ENTRIES;
   localparam int QAW   = $clog2(QDEP);
   localparam int CAPW  = sfc_pkg::CAP_W;
   localparam int CHGW  = sfc_pkg::CHG_W;
   localparam int CW    = sfc_pkg::COUNT_W;
   // Entry word layout: valid, key, bytes, hits, segment.
   localparam int SEG_LO  = 0;
   localparam int HITS_LO = SW;
   localparam int BYTE_LO = HITS_LO + sfc_pkg::HITS_W;
   localparam int KEY_LO  = BYTE_LO + sfc_pkg::SIZE_W;
   localparam int VAL_BIT = KEY_LO + sfc_pkg::KEY_W;
   localparam int EWD     = VAL_BIT + 1;

   sfc_pkg::state_type state_ff, state_in;

   logic [EW-1:0]   clr_ff, clr_in;
   logic [EW:0]     scan_ff, scan_in;
   logic            pend_ff, pend_in;
   logic [EW-1:0]   pend_idx_ff, pend_idx_in;
   logic            free_ok_ff, free_ok_in;
   logic [EW-1:0]   free_idx_ff, free_idx_in;
   logic [EW-1:0]   cur_ff, cur_in;
   logic [EW-1:0]   vic_ff, vic_in;
   logic [sfc_pkg::KEY_W-1:0]  cur_key_ff, cur_key_in;
   logic [sfc_pkg::SIZE_W-1:0] cur_bytes_ff, cur_bytes_in;
   logic [sfc_pkg::HITS_W-1:0] cur_hits_ff, cur_hits_in;
   logic [SW-1:0]   tgt_ff, tgt_in;
   logic [sfc_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [sfc_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [CW-1:0]   evict_ff, evict_in;
   logic [CW-1:0]   promo_ff, promo_in;

   logic [EW-1:0]   head_ff  [MAX_SEGMENTS];
   logic [EW-1:0]   head_in  [MAX_SEGMENTS];
   logic [EW-1:0]   tail_ff  [MAX_SEGMENTS];
   logic [EW-1:0]   tail_in  [MAX_SEGMENTS];
   logic [EW:0]     cnt_ff   [MAX_SEGMENTS];
   logic [EW:0]     cnt_in   [MAX_SEGMENTS];
   logic [CAPW-1:0] bytes_ff [MAX_SEGMENTS];
   logic [CAPW-1:0] bytes_in [MAX_SEGMENTS];
   logic [CAPW-1:0] cap_ff   [MAX_SEGMENTS];
   logic [CAPW-1:0] cap_in   [MAX_SEGMENTS];
   logic [sfc_pkg::SEGS_W-1:0] segs_ff, segs_in;
   logic [sfc_pkg::MD_W-1:0]   md_ff, md_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_hit_ff, rsp_hit_in;
   logic [1:0]      rsp_seg_ff, rsp_seg_in;
   logic            rsp_adm_ff, rsp_adm_in;
   logic            rsp_full_ff, rsp_full_in;
   logic [CW-1:0]   rsp_evict_ff, rsp_evict_in;
   logic [CW-1:0]   rsp_promo_ff, rsp_promo_in;

   logic            e_we;
   logic [EW-1:0]   e_waddr, e_raddr;
   logic [EWD-1:0]  e_wdata, e_rdata;
   logic            q_we;
   logic [QAW-1:0]  q_waddr, q_raddr;
   logic [EW-1:0]   q_wdata, q_rdata;

   function automatic logic [QAW-1:0] qaddr(input logic [SW-1:0] s, input logic [EW-1:0] i);
      qaddr = QAW'(s) * QAW'(MAX_ENTRIES) + QAW'(i);
   endfunction

   function automatic logic [EW-1:0] wrap_inc(input logic [EW-1:0] i);
      wrap_inc = (i == EW'(MAX_ENTRIES - 1)) ? '0 : i + 1'b1;
   endfunction

   sfc_ram #(.WIDTH(EWD), .DEPTH(MAX_ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   sfc_ram #(.WIDTH(EW), .DEPTH(QDEP)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   always_comb begin
      logic                       rd_valid;
      logic [sfc_pkg::KEY_W-1:0]  rd_key;
      logic [sfc_pkg::SIZE_W-1:0] rd_bytes;
      logic [sfc_pkg::HITS_W-1:0] rd_hits;
      logic [SW-1:0]              rd_seg;
      logic [SW+1:0]              seg_wide;
      logic [CHGW-1:0]            chg_req, rd_chg, cur_chg, pop_chg;
      logic [CAPW:0]              sum0, sumt;
      logic [3:0]                 act, act_m1, hits4, t4;
      logic [SW-1:0]              t, pop_seg;
      logic                       do_pop;
      logic [EWD-1:0]             hit_word;

      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      cur_in       = cur_ff;
      vic_in       = vic_ff;
      cur_key_in   = cur_key_ff;
      cur_bytes_in = cur_bytes_ff;
      cur_hits_in  = cur_hits_ff;
      tgt_in       = tgt_ff;
      key_in       = key_ff;
      size_in      = size_ff;
      evict_in     = evict_ff;
      promo_in     = promo_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      bytes_in     = bytes_ff;
      cap_in       = cap_ff;
      segs_in      = segs_ff;
      md_in        = md_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_adm_in   = rsp_adm_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_evict_in = rsp_evict_ff;
      rsp_promo_in = rsp_promo_ff;
      e_we    = 1'b0;
      e_waddr = '0;
      e_wdata = '0;
      e_raddr = '0;
      q_we    = 1'b0;
      q_waddr = '0;
      q_wdata = '0;
      q_raddr = '0;
      do_pop  = 1'b0;
      pop_seg = '0;
      pop_chg = '0;

      rd_valid = e_rdata[VAL_BIT];
      rd_key   = e_rdata[KEY_LO +: sfc_pkg::KEY_W];
      rd_bytes = e_rdata[BYTE_LO +: sfc_pkg::SIZE_W];
      rd_hits  = e_rdata[HITS_LO +: sfc_pkg::HITS_W];
      rd_seg   = e_rdata[SEG_LO +: SW];
      seg_wide = {2'b00, rd_seg};

      chg_req = CHGW'(size_ff) + CHGW'(md_ff);
      rd_chg  = CHGW'(rd_bytes) + CHGW'(md_ff);
      cur_chg = CHGW'(cur_bytes_ff) + CHGW'(md_ff);
      sum0    = {1'b0, bytes_ff[0]} + (CAPW+1)'(chg_req);
      sumt    = {1'b0, bytes_ff[tgt_ff]} + (CAPW+1)'(cur_chg);

      // Segment counts of zero act as one; counts above the build limit saturate.
      if (segs_ff == '0) begin
         act = 4'd1;
      end else if (4'(segs_ff) > 4'(MAX_SEGMENTS)) begin
         act = 4'(MAX_SEGMENTS);
      end else begin
         act = 4'(segs_ff);
      end
      act_m1 = act - 4'd1;
      hits4  = {2'b00, rd_hits};
      t4     = (hits4 < act_m1) ? hits4 : act_m1;
      t      = SW'(t4);

      hit_word = e_rdata;
      hit_word[HITS_LO +: sfc_pkg::HITS_W] =
         (rd_hits < sfc_pkg::HIT_MAX) ? rd_hits + 1'b1 : rd_hits;

      if (csr_wr_en) begin
         unique case (csr_index)
            sfc_pkg::CSR_SEGMENTS: segs_in = csr_wr_data[sfc_pkg::SEGS_W-1:0];
            sfc_pkg::CSR_METADATA: md_in = csr_wr_data[sfc_pkg::MD_W-1:0];
            sfc_pkg::CSR_CAP0, sfc_pkg::CSR_CAP1, sfc_pkg::CSR_CAP2, sfc_pkg::CSR_CAP3: begin
               for (int g = 0; g < MAX_SEGMENTS; g++) begin
                  if (g < sfc_pkg::NUM_CAP_REGS &&
                      csr_index - sfc_pkg::CSR_CAP0 == sfc_pkg::CSR_W'(g)) begin
                     cap_in[g] = csr_wr_data;
                  end
               end
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         sfc_pkg::ST_CLEAR: begin
            e_we    = 1'b1;
            e_waddr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == EW'(MAX_ENTRIES - 1)) begin
               state_in = sfc_pkg::ST_IDLE;
            end
         end
         sfc_pkg::ST_IDLE: begin
            if (start) begin
               key_in     = req_object_key;
               size_in    = req_object_size;
               scan_in    = '0;
               pend_in    = 1'b0;
               free_ok_in = 1'b0;
               evict_in   = '0;
               promo_in   = '0;
               state_in   = sfc_pkg::ST_SCAN;
            end
         end
         sfc_pkg::ST_SCAN: begin
            if (pend_ff && rd_valid && rd_key == key_ff) begin
               e_we         = 1'b1;
               e_waddr      = pend_idx_ff;
               e_wdata      = hit_word;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_seg_in   = seg_wide[1:0];
               rsp_adm_in   = 1'b0;
               rsp_full_in  = 1'b0;
               rsp_evict_in = '0;
               rsp_promo_in = '0;
               state_in     = sfc_pkg::ST_IDLE;
            end else begin
               if (pend_ff && !rd_valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = pend_idx_ff;
               end
               if (scan_ff < (EW+1)'(MAX_ENTRIES)) begin
                  e_raddr     = scan_ff[EW-1:0];
                  pend_in     = 1'b1;
                  pend_idx_in = scan_ff[EW-1:0];
                  scan_in     = scan_ff + 1'b1;
               end else begin
                  pend_in  = 1'b0;
                  state_in = sfc_pkg::ST_MISS;
               end
            end
         end
         sfc_pkg::ST_MISS: begin
            rsp_hit_in   = 1'b0;
            rsp_seg_in   = '0;
            rsp_adm_in   = 1'b0;
            rsp_full_in  = 1'b0;
            rsp_evict_in = evict_ff;
            rsp_promo_in = promo_ff;
            if (CAPW'(chg_req) > cap_ff[0]) begin
               rsp_valid_in = 1'b1;
               state_in     = sfc_pkg::ST_IDLE;
            end else if (cnt_ff[0] != '0 && (sum0 > {1'b0, cap_ff[0]} || !free_ok_ff)) begin
               q_raddr  = qaddr('0, tail_ff[0]);
               state_in = sfc_pkg::ST_Q0;
            end else if (free_ok_ff) begin
               e_we    = 1'b1;
               e_waddr = free_idx_ff;
               e_wdata = {1'b1, key_ff, size_ff, {sfc_pkg::HITS_W{1'b0}}, {SW{1'b0}}};
               q_we    = 1'b1;
               q_waddr = qaddr('0, head_ff[0]);
               q_wdata = free_idx_ff;
               head_in[0]   = wrap_inc(head_ff[0]);
               cnt_in[0]    = cnt_ff[0] + 1'b1;
               bytes_in[0]  = sum0[CAPW-1:0];
               rsp_adm_in   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sfc_pkg::ST_IDLE;
            end else begin
               rsp_full_in  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sfc_pkg::ST_IDLE;
            end
         end
         sfc_pkg::ST_Q0: begin
            e_raddr  = q_rdata;
            cur_in   = q_rdata;
            state_in = sfc_pkg::ST_E0;
         end
         sfc_pkg::ST_E0: begin
            do_pop       = 1'b1;
            pop_seg      = '0;
            pop_chg      = rd_chg;
            cur_key_in   = rd_key;
            cur_bytes_in = rd_bytes;
            cur_hits_in  = rd_hits;
            if (t == '0 || CAPW'(rd_chg) > cap_ff[t]) begin
               // No hits, a single active segment, or too big for its promotion segment: the entry is dropped.
               e_we     = 1'b1;
               e_waddr  = cur_ff;
               evict_in = evict_ff + 1'b1;
               if (!free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = cur_ff;
               end
               state_in = sfc_pkg::ST_MISS;
            end else begin
               tgt_in   = t;
               state_in = sfc_pkg::ST_PCHK;
            end
         end
         sfc_pkg::ST_PCHK: begin
            if (cnt_ff[tgt_ff] != '0 && sumt > {1'b0, cap_ff[tgt_ff]}) begin
               q_raddr  = qaddr(tgt_ff, tail_ff[tgt_ff]);
               state_in = sfc_pkg::ST_QT;
            end else begin
               q_we    = 1'b1;
               q_waddr = qaddr(tgt_ff, head_ff[tgt_ff]);
               q_wdata = cur_ff;
               e_we    = 1'b1;
               e_waddr = cur_ff;
               e_wdata = {1'b1, cur_key_ff, cur_bytes_ff, cur_hits_ff, tgt_ff};
               head_in[tgt_ff]  = wrap_inc(head_ff[tgt_ff]);
               cnt_in[tgt_ff]   = cnt_ff[tgt_ff] + 1'b1;
               bytes_in[tgt_ff] = sumt[CAPW-1:0];
               promo_in = promo_ff + 1'b1;
               state_in = sfc_pkg::ST_MISS;
            end
         end
         sfc_pkg::ST_QT: begin
            e_raddr  = q_rdata;
            vic_in   = q_rdata;
            state_in = sfc_pkg::ST_ET;
         end
         sfc_pkg::ST_ET: begin
            do_pop   = 1'b1;
            pop_seg  = tgt_ff;
            pop_chg  = rd_chg;
            e_we     = 1'b1;
            e_waddr  = vic_ff;
            evict_in = evict_ff + 1'b1;
            if (!free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = vic_ff;
            end
            state_in = sfc_pkg::ST_PCHK;
         end
         default: state_in = sfc_pkg::ST_IDLE;
      endcase

      // Removal from a segment's tail; the byte count saturates at zero and is
      // cleared outright when the segment empties.
      if (do_pop) begin
         tail_in[pop_seg] = wrap_inc(tail_ff[pop_seg]);
         cnt_in[pop_seg]  = cnt_ff[pop_seg] - 1'b1;
         if (cnt_ff[pop_seg] == (EW+1)'(1) || bytes_ff[pop_seg] <= CAPW'(pop_chg)) begin
            bytes_in[pop_seg] = '0;
         end else begin
            bytes_in[pop_seg] = bytes_ff[pop_seg] - CAPW'(pop_chg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         segs_ff      <= sfc_pkg::SEGS_RESET;
         md_ff        <= sfc_pkg::MD_RESET;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < MAX_SEGMENTS; s++) begin
            head_ff[s]  <= '0;
            tail_ff[s]  <= '0;
            cnt_ff[s]   <= '0;
            bytes_ff[s] <= '0;
            cap_ff[s]   <= sfc_pkg::CAP_RESET;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         segs_ff      <= segs_in;
         md_ff        <= md_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         bytes_ff     <= bytes_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      pend_ff      <= pend_in;
      pend_idx_ff  <= pend_idx_in;
      free_ok_ff   <= free_ok_in;
      free_idx_ff  <= free_idx_in;
      cur_ff       <= cur_in;
      vic_ff       <= vic_in;
      cur_key_ff   <= cur_key_in;
      cur_bytes_ff <= cur_bytes_in;
      cur_hits_ff  <= cur_hits_in;
      tgt_ff       <= tgt_in;
      key_ff       <= key_in;
      size_ff      <= size_in;
      evict_ff     <= evict_in;
      promo_ff     <= promo_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_adm_ff   <= rsp_adm_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_promo_ff <= rsp_promo_in;
   end

   assign busy               = (state_ff != sfc_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_hit_segment    = rsp_seg_ff;
   assign rsp_admitted       = rsp_adm_ff;
   assign rsp_table_full     = rsp_full_ff;
   assign rsp_evicted_count  = rsp_evict_ff;
   assign rsp_promoted_count = rsp_promo_ff;

endmodule

@@ hw/rtl/sfc_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
